@@ sv/isort_pkg.sv @@
// Shared types and constants of the insertion sorter.
package isort_pkg;

   localparam int DATA_W      = 32;
   localparam int CAP_DEFAULT = 32;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              last;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] sorted_value;
      logic              final_res;
      logic              overflow;
   } rsp_type;

   // Per-cycle command broadcast to every cell of the chain.
   typedef struct packed {
      logic insert;
      logic shift;
   } cell_ctrl_type;

endpackage

@@ sv/isort_cell.sv @@
// One cell of the sorting chain: holds a single stored value.
module isort_cell (
   input  logic                           clock,
   input  isort_pkg::cell_ctrl_type       ctrl,
   input  logic [isort_pkg::DATA_W-1:0]   ins_value,
   input  logic                           valid_here,
   input  logic                           valid_left,
   input  logic [isort_pkg::DATA_W-1:0]   left_value,
   input  logic                           left_greater,
   input  logic [isort_pkg::DATA_W-1:0]   right_value,
   output logic [isort_pkg::DATA_W-1:0]   value,
   output logic                           greater
);
   import isort_pkg::*;

   logic [DATA_W-1:0] value_ff;
   logic [DATA_W-1:0] value_in;
   logic              take;

   assign greater = valid_here && (value_ff > ins_value);
   // A cell moves when its entry lies above the new value, or when it is
   // the first empty cell right after the filled ones.
   assign take    = greater || (!valid_here && valid_left);
   assign value   = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctrl.shift) begin
         value_in = right_value;
      end else if (ctrl.insert && take) begin
         value_in = left_greater ? left_value : ins_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

@@ sv/insertion_sorter.sv @@
// Stable ascending insertion sorter built from a chain of compare-and-shift cells.
// Throughput: one value accepted per cycle while a run is being collected.
// After the item marked last, the run drains one result per rsp transfer, the first
// result offered in the cycle after that item; input stays blocked until the final result leaves.
// Synchronous reset empties the store and clears the overflow flag; cell data is not reset.
module insertion_sorter #(
   parameter int CAPACITY = isort_pkg::CAP_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  isort_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output isort_pkg::rsp_type rsp_data
);
   import isort_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   logic [CW-1:0]     fill_ff, fill_in;
   logic              dropped_ff, dropped_in;
   logic              drain_ff, drain_in;
   logic              req_xfer, rsp_xfer, full;
   cell_ctrl_type     ctrl;
   logic [DATA_W-1:0] cell_value [CAPACITY];
   logic              cell_greater [CAPACITY];
   logic              cell_valid [CAPACITY];

   assign req_ready = !drain_ff;
   assign req_xfer  = req_valid && req_ready;
   assign rsp_valid = drain_ff;
   assign rsp_xfer  = rsp_valid && rsp_ready;
   assign full      = (fill_ff == CW'(CAPACITY));

   assign ctrl.insert = req_xfer && !full;
   assign ctrl.shift  = rsp_xfer;

   assign rsp_data.sorted_value = cell_value[0];
   assign rsp_data.final_res    = (fill_ff == CW'(1));
   assign rsp_data.overflow     = dropped_ff;

   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : g_cell
         logic [DATA_W-1:0] left_value, right_value;
         logic              left_greater, valid_left;

         assign cell_valid[i] = (CW'(i) < fill_ff);

         if (i == 0) begin : g_first
            assign left_value   = '0;
            assign left_greater = 1'b0;
            assign valid_left   = 1'b1;
         end else begin : g_rest
            assign left_value   = cell_value[i-1];
            assign left_greater = cell_greater[i-1];
            assign valid_left   = cell_valid[i-1];
         end

         if (i == CAPACITY - 1) begin : g_end
            assign right_value = cell_value[i];
         end else begin : g_mid
            assign right_value = cell_value[i+1];
         end

         isort_cell u_cell (
            .clock        (clock),
            .ctrl         (ctrl),
            .ins_value    (req_data.value),
            .valid_here   (cell_valid[i]),
            .valid_left   (valid_left),
            .left_value   (left_value),
            .left_greater (left_greater),
            .right_value  (right_value),
            .value        (cell_value[i]),
            .greater      (cell_greater[i])
         );
      end
   endgenerate

   always_comb begin
      fill_in    = fill_ff;
      dropped_in = dropped_ff;
      drain_in   = drain_ff;
      if (req_xfer) begin
         if (full) begin
            dropped_in = 1'b1;
         end else begin
            fill_in = fill_ff + CW'(1);
         end
         if (req_data.last) begin
            drain_in = 1'b1;
         end
      end
      if (rsp_xfer) begin
         fill_in = fill_ff - CW'(1);
         if (fill_ff == CW'(1)) begin
            drain_in   = 1'b0;
            dropped_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         dropped_ff <= 1'b0;
         drain_ff   <= 1'b0;
      end else begin
         fill_ff    <= fill_in;
         dropped_ff <= dropped_in;
         drain_ff   <= drain_in;
      end
   end

endmodule
